// File: sv/deque_with_match_count_and_remove_defines.svh
// assertion helpers shared by the deque rtl
`ifndef DEQUE_WITH_MATCH_COUNT_AND_REMOVE_DEFINES_SVH
`define DEQUE_WITH_MATCH_COUNT_AND_REMOVE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define DQM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define DQM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/dqm_pkg.sv
package dqm_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [2:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [2:0] FUNC_COUNT      = 3'd4;
  localparam logic [2:0] FUNC_REMOVE     = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] data_value;
  } dqm_req_t;

  typedef struct packed {
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         entry_count;
    logic [4:0]         match_total;
    logic [1:0]         status;
  } dqm_rsp_t;

  // per-cell control, priority load > shift up > shift down > hold
  typedef struct packed {
    logic shift_up;
    logic shift_dn;
    logic load;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } dqm_state_e;

endpackage

// File: sv/dqm_cell.sv
module dqm_cell (
  input  logic               clk_i,
  input  dqm_pkg::cell_ctrl_t ctrl_i,
  input  dqm_pkg::word_t     load_val_i,
  input  dqm_pkg::word_t     left_i,
  input  dqm_pkg::word_t     right_i,
  output dqm_pkg::word_t     data_o
);

  dqm_pkg::word_t data_q;
  dqm_pkg::word_t data_d;

  always_comb begin
    if (ctrl_i.load) begin
      data_d = load_val_i;
    end else if (ctrl_i.shift_up) begin
      data_d = left_i;
    end else if (ctrl_i.shift_dn) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: sv/deque_with_match_count_and_remove.sv
// push and pop go from the request through the done state to the output register
// count and remove first walk the held entries at the head cell in the scan state
// one request at a time, a new request is taken only in the idle state
// a finished result waits in the output register while the next request is taken
// reset empties the list (fill 0) and clears the output valid, no clearing pass
`include "deque_with_match_count_and_remove_defines.svh"

module deque_with_match_count_and_remove (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dqm_pkg::dqm_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dqm_pkg::dqm_rsp_t out_rsp_o
);

  localparam int unsigned DEPTH = dqm_pkg::DEPTH;
  localparam int unsigned CNT_W = dqm_pkg::CNT_W;
  localparam int unsigned IDX_W = dqm_pkg::IDX_W;

  dqm_pkg::dqm_state_e state_q, state_d;
  logic [2:0]          func_q, func_d;
  dqm_pkg::word_t      val_q, val_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [CNT_W-1:0]    n_q, n_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [CNT_W-1:0]    match_q, match_d;
  logic [1:0]          status_q, status_d;
  logic                out_valid_q, out_valid_d;
  dqm_pkg::dqm_rsp_t   out_q, out_d;

  dqm_pkg::word_t      cell_q [DEPTH];
  dqm_pkg::cell_ctrl_t cell_ctrl [DEPTH];
  dqm_pkg::word_t      load_val;
  logic                load_en;
  logic [IDX_W-1:0]    load_idx;
  logic                shift_up;
  logic                shift_dn;

  logic                accept;
  logic                full;
  logic                empty;
  logic                out_free;
  dqm_pkg::word_t      head;
  logic                hit;
  logic                scan_keep;
  logic                scan_last;
  logic [CNT_W-1:0]    scan_pos;
  logic [CNT_W:0]      scan_sum;
  logic [CNT_W-1:0]    back_pos;
  logic                scan_ok;
  logic                rsp_full;
  logic                rsp_empty;

  // chain of cells, cell 0 is the front
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [IDX_W-1:0] CellIdx = IDX_W'(g);
    dqm_pkg::word_t left_val;
    dqm_pkg::word_t right_val;

    if (g == 0) begin : g_first
      assign left_val = load_val;
    end else begin : g_mid_l
      assign left_val = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_val = cell_q[g];
    end else begin : g_mid_r
      assign right_val = cell_q[g+1];
    end

    assign cell_ctrl[g] = '{shift_up: shift_up,
                            shift_dn: shift_dn,
                            load:     load_en && (load_idx == CellIdx)};

    dqm_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl[g]),
      .load_val_i (load_val),
      .left_i     (left_val),
      .right_i    (right_val),
      .data_o     (cell_q[g])
    );
  end

  assign in_ready_o  = (state_q == dqm_pkg::ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign full        = (fill_q == CNT_W'(DEPTH));
  assign empty       = (fill_q == '0);
  assign out_free    = !out_valid_q || out_ready_i;
  assign head        = cell_q[0];
  assign hit         = (head == val_q);
  // count keeps everything, remove drops the hits
  assign scan_keep   = !hit || (func_q == dqm_pkg::FUNC_COUNT);
  assign scan_last   = (n_q == CNT_W'(1));
  // unscanned entries sit below the kept ones, append after the shift
  assign scan_pos    = n_q + k_q - CNT_W'(1);
  assign scan_sum    = {1'b0, n_q} + {1'b0, k_q};
  assign back_pos    = fill_q - CNT_W'(1);
  assign load_val    = (state_q == dqm_pkg::ST_SCAN) ? head : in_req_i.data_value;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dqm_pkg::ST_IDLE: begin
        if (accept) begin
          if (((in_req_i.func == dqm_pkg::FUNC_COUNT) ||
               (in_req_i.func == dqm_pkg::FUNC_REMOVE)) && !empty) begin
            state_d = dqm_pkg::ST_SCAN;
          end else begin
            state_d = dqm_pkg::ST_DONE;
          end
        end
      end
      dqm_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = dqm_pkg::ST_DONE;
        end
      end
      dqm_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = dqm_pkg::ST_IDLE;
        end
      end
      default: state_d = dqm_pkg::ST_IDLE;
    endcase
  end

  // cell control and datapath
  always_comb begin
    func_d      = func_q;
    val_d       = val_q;
    fill_d      = fill_q;
    n_d         = n_q;
    k_d         = k_q;
    match_d     = match_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    shift_up    = 1'b0;
    shift_dn    = 1'b0;
    load_en     = 1'b0;
    load_idx    = '0;
    case (state_q)
      dqm_pkg::ST_IDLE: begin
        if (accept) begin
          func_d   = in_req_i.func;
          val_d    = in_req_i.data_value;
          status_d = dqm_pkg::STAT_OK;
          match_d  = '0;
          n_d      = fill_q;
          k_d      = '0;
          case (in_req_i.func)
            dqm_pkg::FUNC_PUSH_FRONT: begin
              if (full) begin
                status_d = dqm_pkg::STAT_FULL;
              end else begin
                shift_up = 1'b1;
                load_en  = 1'b1;
                load_idx = '0;
                fill_d   = fill_q + CNT_W'(1);
              end
            end
            dqm_pkg::FUNC_PUSH_BACK: begin
              if (full) begin
                status_d = dqm_pkg::STAT_FULL;
              end else begin
                load_en  = 1'b1;
                load_idx = fill_q[IDX_W-1:0];
                fill_d   = fill_q + CNT_W'(1);
              end
            end
            dqm_pkg::FUNC_POP_FRONT: begin
              if (empty) begin
                status_d = dqm_pkg::STAT_EMPTY;
              end else begin
                shift_dn = 1'b1;
                fill_d   = fill_q - CNT_W'(1);
              end
            end
            dqm_pkg::FUNC_POP_BACK: begin
              if (empty) begin
                status_d = dqm_pkg::STAT_EMPTY;
              end else begin
                fill_d = fill_q - CNT_W'(1);
              end
            end
            default: ;
          endcase
        end
      end
      dqm_pkg::ST_SCAN: begin
        shift_dn = 1'b1;
        load_en  = scan_keep;
        load_idx = scan_pos[IDX_W-1:0];
        n_d      = n_q - CNT_W'(1);
        k_d      = k_q + CNT_W'(scan_keep);
        match_d  = match_q + CNT_W'(hit);
        if (scan_last) begin
          fill_d = k_q + CNT_W'(scan_keep);
        end
      end
      dqm_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.front_value = empty ? -32'sd1 : cell_q[0];
          out_d.back_value  = empty ? -32'sd1 : cell_q[back_pos[IDX_W-1:0]];
          out_d.entry_count = 5'(fill_q);
          out_d.match_total = 5'(match_q);
          out_d.status      = status_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqm_pkg::ST_IDLE;
      fill_q      <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q   <= func_d;
    val_q    <= val_d;
    match_q  <= match_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  assign scan_ok   = (n_q != '0) && (scan_sum <= (CNT_W+1)'(fill_q));
  assign rsp_full  = out_valid_o && (out_rsp_o.status == dqm_pkg::STAT_FULL);
  assign rsp_empty = out_valid_o && (out_rsp_o.status == dqm_pkg::STAT_EMPTY);

  `DQM_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CNT_W'(DEPTH), "fill beyond depth")
  `DQM_ASSERT_NEXT(a_busy_after_req, accept, state_q != dqm_pkg::ST_IDLE, "idle after request")
  `DQM_ASSERT_NOW(a_scan_range, state_q == dqm_pkg::ST_SCAN, scan_ok, "scan counters out of range")
  `DQM_ASSERT_NOW(a_full_count, rsp_full, out_rsp_o.entry_count == 5'(DEPTH), "refused push below depth")
  `DQM_ASSERT_NOW(a_empty_count, rsp_empty, out_rsp_o.entry_count == 5'd0, "ignored pop when not empty")

endmodule
